// ===== sv/rsp_pkg.sv =====
// Shared constants, tables and types for the range scan point projection core.
// Holds the CORDIC arctangent table, fixed-point widths and register indexes.
// No dependencies.
package rsp_pkg;

    localparam int MAX_BEAMS    = 4096;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 32;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 24;
    localparam int BEAM_W  = 12;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    localparam int MAG_W   = 32;
    localparam int CW      = 35;
    localparam int ZW      = 33;
    localparam int AW      = 53;
    localparam int RND_SH  = 30;
    localparam int SH_W    = AW - RND_SH;
    localparam int SUM_W   = OUT_W + 1;
    localparam int STEP_W  = $clog2(ATAN_ENTRIES);
    localparam int BIT_W   = $clog2(COEF_W);

    localparam int BEAM_LIMIT = (MAX_BEAMS < 4096) ? MAX_BEAMS : 4096;

    localparam logic [RANGE_W-1:0] GAIN_Q16  = 16'd39797;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [IDX_W-1:0] REG_ANGLE_START = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIN_LO      = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIN_HI      = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROT_ROW_X   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROT_ROW_Y   = 3'd5;
    localparam logic [IDX_W-1:0] REG_OFFSET_X    = 3'd6;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y    = 3'd7;

    localparam logic [RANGE_W-1:0] WIN_HI_RST = 16'hFFFF;
    localparam logic [CFG_W-1:0]   ROT_X_RST  = 32'h0000_4000;
    localparam logic [CFG_W-1:0]   ROT_Y_RST  = 32'h4000_0000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7F_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh80_0000;

    localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } cordic_out_t;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] value;
    } proj_out_t;

endpackage

// ===== sv/rsp_cordic.sv =====
// Iterative CORDIC rotator, one micro-rotation per cycle over a shared adder set.
// Loads a magnitude and binary angle, folds the left half plane, runs the steps.
// Depends on rsp_pkg.
module rsp_cordic (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rsp_pkg::MAG_W-1:0]    mag,
    input  logic [rsp_pkg::ANGLE_W-1:0]  angle,
    output rsp_pkg::cordic_out_t         res
);

    logic signed [rsp_pkg::CW-1:0] x_reg, x_next;
    logic signed [rsp_pkg::CW-1:0] y_reg, y_next;
    logic signed [rsp_pkg::ZW-1:0] z_reg, z_next;
    logic [rsp_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic                          flip;
    logic [rsp_pkg::ANGLE_W-1:0]   u;
    logic signed [rsp_pkg::CW-1:0] mag_ext;
    logic signed [rsp_pkg::CW-1:0] dx;
    logic signed [rsp_pkg::CW-1:0] dy;
    logic signed [rsp_pkg::ZW-1:0] atan;
    logic                          last;

    always_comb
    begin
        flip    = angle[rsp_pkg::ANGLE_W-1] ^ angle[rsp_pkg::ANGLE_W-2];
        u       = flip ? (angle ^ rsp_pkg::HALF_TURN) : angle;
        mag_ext = $signed({{(rsp_pkg::CW-rsp_pkg::MAG_W){1'b0}}, mag});
        dx      = y_reg >>> step_reg;
        dy      = x_reg >>> step_reg;
        atan    = $signed({{(rsp_pkg::ZW-rsp_pkg::ANGLE_W){1'b0}}, rsp_pkg::ATAN_TAB[step_reg]});
        last    = (step_reg == rsp_pkg::STEP_W'(rsp_pkg::CORDIC_STEPS - 1));

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            x_next    = flip ? -mag_ext : mag_ext;
            y_next    = '0;
            z_next    = $signed({{(rsp_pkg::ZW-rsp_pkg::ANGLE_W){u[rsp_pkg::ANGLE_W-1]}}, u});
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[rsp_pkg::ZW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan;
            end
            step_next = step_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign res.done = done_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;

endmodule

// ===== sv/rsp_proj.sv =====
// Bit-serial projection of one output axis: x*ca + y*cb, rounded, offset, saturated.
// Walks the coefficient bits LSB first through shift registers, one bit per cycle.
// Depends on rsp_pkg.
module rsp_proj (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [rsp_pkg::CW-1:0]     xc,
    input  logic signed [rsp_pkg::CW-1:0]     yc,
    input  logic [rsp_pkg::COEF_W-1:0]        coef_a,
    input  logic [rsp_pkg::COEF_W-1:0]        coef_b,
    input  logic signed [rsp_pkg::OUT_W-1:0]  offset,
    output rsp_pkg::proj_out_t                res
);

    logic signed [rsp_pkg::AW-1:0]  xs_reg, xs_next;
    logic signed [rsp_pkg::AW-1:0]  ys_reg, ys_next;
    logic signed [rsp_pkg::AW-1:0]  acc_reg, acc_next;
    logic [rsp_pkg::COEF_W-1:0]     ca_reg, ca_next;
    logic [rsp_pkg::COEF_W-1:0]     cb_reg, cb_next;
    logic [rsp_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic                           busy_reg, busy_next;
    logic                           fin_reg, fin_next;

    logic                           last;
    logic signed [rsp_pkg::AW-1:0]  pa;
    logic signed [rsp_pkg::AW-1:0]  pb;
    logic signed [rsp_pkg::SH_W-1:0]  rounded;
    logic signed [rsp_pkg::SUM_W-1:0] sum;

    always_comb
    begin
        last = (bit_reg == rsp_pkg::BIT_W'(rsp_pkg::COEF_W - 1));
        pa   = ca_reg[0] ? xs_reg : '0;
        pb   = cb_reg[0] ? ys_reg : '0;

        xs_next   = xs_reg;
        ys_next   = ys_reg;
        acc_next  = acc_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;

        if (start)
        begin
            xs_next   = rsp_pkg::AW'(xc);
            ys_next   = rsp_pkg::AW'(yc);
            acc_next  = rsp_pkg::AW'(1) <<< (rsp_pkg::RND_SH - 1);
            ca_next   = coef_a;
            cb_next   = coef_b;
            bit_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // sign bit of a two's complement coefficient carries negative weight
            if (last)
                acc_next = acc_reg - pa - pb;
            else
                acc_next = acc_reg + pa + pb;
            xs_next  = xs_reg <<< 1;
            ys_next  = ys_reg <<< 1;
            ca_next  = ca_reg >> 1;
            cb_next  = cb_reg >> 1;
            bit_next = bit_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        rounded = acc_reg[rsp_pkg::AW-1:rsp_pkg::RND_SH];
        sum     = rsp_pkg::SUM_W'(rounded) + rsp_pkg::SUM_W'(offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg  <= xs_next;
        ys_reg  <= ys_next;
        acc_reg <= acc_next;
        ca_reg  <= ca_next;
        cb_reg  <= cb_next;
    end

    always_comb
    begin
        res.done = fin_reg;
        if (sum[rsp_pkg::SUM_W-1] != sum[rsp_pkg::SUM_W-2])
            res.value = sum[rsp_pkg::SUM_W-1] ? rsp_pkg::OUT_MIN : rsp_pkg::OUT_MAX;
        else
            res.value = sum[rsp_pkg::OUT_W-1:0];
    end

endmodule

// ===== sv/range_scan_to_point_projection_core.sv =====
// Top level of the range scan point projection core: config registers, beam
// angle tracking, sequencing of the CORDIC and the two bit-serial projectors.
// Depends on rsp_pkg, rsp_cordic, rsp_proj.
//
//   port group   direction  handshake            payload
//   in           in         in_valid/in_ready    range_mm, reading_ok, first_of_scan
//   out          out        out_valid/out_ready  point_x, point_y, beam_index
//   cfg          in         cfg_wr_en            cfg_index, cfg_data
//
// A reading outside the window returns straight to idle; a reading that yields
// a point passes, before the next input transfer, through the transfer, a gain
// multiply, a load, the CORDIC micro-rotations and their done, the serial
// projection over the coefficient bits and its done, and an output step.
// The output step stalls while the output register still holds an unaccepted
// point.
// The next reading is taken while a finished point waits in the output register.
// Reset clears the beam angle and beam counter and sets all config registers to defaults.
module range_scan_to_point_projection_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rsp_pkg::RANGE_W-1:0]        range_mm,
    input  logic                               reading_ok,
    input  logic                               first_of_scan,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rsp_pkg::OUT_W-1:0]   point_x,
    output logic signed [rsp_pkg::OUT_W-1:0]   point_y,
    output logic [rsp_pkg::BEAM_W-1:0]         beam_index,
    input  logic                               cfg_wr_en,
    input  logic [rsp_pkg::IDX_W-1:0]          cfg_index,
    input  logic [rsp_pkg::CFG_W-1:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GAIN   = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_CORDIC = 3'd3;
    localparam logic [2:0] ST_PROJ   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [rsp_pkg::ANGLE_W-1:0]      angle_start_reg;
    logic [rsp_pkg::ANGLE_W-1:0]      angle_step_reg;
    logic [rsp_pkg::RANGE_W-1:0]      win_lo_reg;
    logic [rsp_pkg::RANGE_W-1:0]      win_hi_reg;
    logic [rsp_pkg::CFG_W-1:0]        rot_row_x_reg;
    logic [rsp_pkg::CFG_W-1:0]        rot_row_y_reg;
    logic signed [rsp_pkg::OUT_W-1:0] offset_x_reg;
    logic signed [rsp_pkg::OUT_W-1:0] offset_y_reg;

    logic [rsp_pkg::ANGLE_W-1:0] beam_angle_reg, beam_angle_next;
    logic [rsp_pkg::BEAM_W-1:0]  beam_count_reg, beam_count_next;

    logic [rsp_pkg::RANGE_W-1:0] range_reg, range_next;
    logic [rsp_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    logic [rsp_pkg::BEAM_W-1:0]  idx_reg, idx_next;
    logic [rsp_pkg::MAG_W-1:0]   prod_reg, prod_next;

    logic                             out_valid_reg, out_valid_next;
    logic signed [rsp_pkg::OUT_W-1:0] point_x_reg, point_x_next;
    logic signed [rsp_pkg::OUT_W-1:0] point_y_reg, point_y_next;
    logic [rsp_pkg::BEAM_W-1:0]       beam_index_reg, beam_index_next;

    logic                        in_xfer;
    logic                        in_window;
    logic [rsp_pkg::ANGLE_W-1:0] cur_angle;
    logic [rsp_pkg::BEAM_W-1:0]  cur_idx;
    logic [rsp_pkg::BEAM_W:0]    idx_inc;
    logic                        cordic_start;

    rsp_pkg::cordic_out_t cordic_res;
    rsp_pkg::proj_out_t   proj_x_res;
    rsp_pkg::proj_out_t   proj_y_res;

    rsp_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .mag   (prod_reg),
        .angle (angle_reg),
        .res   (cordic_res)
    );

    rsp_proj u_proj_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_res.done),
        .xc     (cordic_res.x),
        .yc     (cordic_res.y),
        .coef_a (rot_row_x_reg[rsp_pkg::COEF_W-1:0]),
        .coef_b (rot_row_x_reg[2*rsp_pkg::COEF_W-1:rsp_pkg::COEF_W]),
        .offset (offset_x_reg),
        .res    (proj_x_res)
    );

    rsp_proj u_proj_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_res.done),
        .xc     (cordic_res.x),
        .yc     (cordic_res.y),
        .coef_a (rot_row_y_reg[rsp_pkg::COEF_W-1:0]),
        .coef_b (rot_row_y_reg[2*rsp_pkg::COEF_W-1:rsp_pkg::COEF_W]),
        .offset (offset_y_reg),
        .res    (proj_y_res)
    );

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        in_xfer      = in_valid && in_ready;
        cordic_start = (state_reg == ST_LOAD);
        in_window    = reading_ok && (range_mm >= win_lo_reg) && (range_mm <= win_hi_reg);
        cur_angle    = first_of_scan ? angle_start_reg : beam_angle_reg;
        cur_idx      = first_of_scan ? '0 : beam_count_reg;
        idx_inc      = {1'b0, cur_idx} + 1'b1;

        state_next      = state_reg;
        beam_angle_next = beam_angle_reg;
        beam_count_next = beam_count_reg;
        range_next      = range_reg;
        angle_next      = angle_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        point_x_next    = point_x_reg;
        point_y_next    = point_y_reg;
        beam_index_next = beam_index_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    beam_angle_next = cur_angle + angle_step_reg;
                    if (idx_inc >= (rsp_pkg::BEAM_W + 1)'(rsp_pkg::BEAM_LIMIT))
                        beam_count_next = '0;
                    else
                        beam_count_next = idx_inc[rsp_pkg::BEAM_W-1:0];
                    range_next = range_mm;
                    angle_next = cur_angle;
                    idx_next   = cur_idx;
                    if (in_window)
                        state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                prod_next  = {{(rsp_pkg::MAG_W-rsp_pkg::RANGE_W){1'b0}}, range_reg}
                           * {{(rsp_pkg::MAG_W-rsp_pkg::RANGE_W){1'b0}}, rsp_pkg::GAIN_Q16};
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (cordic_res.done)
                    state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                if (proj_x_res.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    point_x_next    = proj_x_res.value;
                    point_y_next    = proj_y_res.value;
                    beam_index_next = idx_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            beam_angle_reg <= '0;
            beam_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            beam_angle_reg <= beam_angle_next;
            beam_count_reg <= beam_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            win_lo_reg      <= '0;
            win_hi_reg      <= rsp_pkg::WIN_HI_RST;
            rot_row_x_reg   <= rsp_pkg::ROT_X_RST;
            rot_row_y_reg   <= rsp_pkg::ROT_Y_RST;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rsp_pkg::REG_ANGLE_START: angle_start_reg <= cfg_data;
                rsp_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                rsp_pkg::REG_WIN_LO:      win_lo_reg      <= cfg_data[rsp_pkg::RANGE_W-1:0];
                rsp_pkg::REG_WIN_HI:      win_hi_reg      <= cfg_data[rsp_pkg::RANGE_W-1:0];
                rsp_pkg::REG_ROT_ROW_X:   rot_row_x_reg   <= cfg_data;
                rsp_pkg::REG_ROT_ROW_Y:   rot_row_y_reg   <= cfg_data;
                rsp_pkg::REG_OFFSET_X:    offset_x_reg    <= cfg_data[rsp_pkg::OUT_W-1:0];
                rsp_pkg::REG_OFFSET_Y:    offset_y_reg    <= cfg_data[rsp_pkg::OUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg      <= range_next;
        angle_reg      <= angle_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        point_x_reg    <= point_x_next;
        point_y_reg    <= point_y_next;
        beam_index_reg <= beam_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign beam_index = beam_index_reg;

endmodule
